// ----- sv/trlf_pkg.sv -----
// Shared types and constants for the telnet refusing line framer.
// No dependencies.
`timescale 1ns / 1ps

package trlf_pkg;

  localparam int unsigned LINE_LIMIT_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned LEN_W          = 11;
  localparam int unsigned BYTE_W         = 8;

  localparam logic [7:0] B_NUL  = 8'h00;
  localparam logic [7:0] B_LF   = 8'h0A;
  localparam logic [7:0] B_CR   = 8'h0D;
  localparam logic [7:0] B_IAC  = 8'hFF;
  localparam logic [7:0] B_DONT = 8'hFE;
  localparam logic [7:0] B_DO   = 8'hFD;
  localparam logic [7:0] B_WONT = 8'hFC;
  localparam logic [7:0] B_WILL = 8'hFB;
  localparam logic [7:0] B_ZERO = 8'h00;

  localparam logic REG_TELNET_ANSWER = 1'b0;
  localparam logic REG_MAX_LINE_LEN  = 1'b1;

  typedef enum logic [1:0] {
    K_CHAR  = 2'd0,
    K_END   = 2'd1,
    K_REPLY = 2'd2,
    K_EMPTY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_CHAR     = 3'd0,
    OP_CHAR_END = 3'd1,
    OP_END      = 3'd2,
    OP_EMPTY    = 3'd3,
    OP_REPLY    = 3'd4
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] byte_a;  // character or option
    logic [BYTE_W-1:0] byte_b;  // reply code
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic             telnet_answer;
    logic [LEN_W-1:0] max_line_len;
  } cfg_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

endpackage

// ----- sv/trlf_queue.sv -----
// Small register FIFO between the classifier and the result sequencer.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module trlf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- sv/trlf_front.sv -----
// Front end: accepts input transactions, tracks line length and telnet
// command phase, and queues at most one action per byte. Uses trlf_pkg.
`timescale 1ns / 1ps

module trlf_front
  import trlf_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = LINE_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        stream_end_i,
  output push_t       push_o
);

  localparam int unsigned CW = $clog2(LINE_LIMIT + 1);
  localparam int unsigned LW = (CW > LEN_W) ? CW : LEN_W;

  typedef enum logic [2:0] {
    PH_TEXT = 3'b001,
    PH_CMD  = 3'b010,
    PH_OPT  = 3'b100
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [7:0]     reply_q, reply_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  cnt_inc;
  logic [LW-1:0]  lim, max_ext, cnt_ext, inc_ext;
  logic           is_text, is_term;

  assign cnt_inc = cnt_q + 1'b1;
  assign cnt_ext = LW'(cnt_q);
  assign inc_ext = LW'(cnt_inc);
  assign max_ext = LW'(cfg_i.max_line_len);
  assign is_term = (rx_byte_i == B_LF) || (rx_byte_i == B_CR) || (rx_byte_i == B_NUL);

  always_comb begin
    lim = max_ext;
    if (lim == '0) begin
      lim = LW'(1);
    end
    if (lim > LW'(LINE_LIMIT)) begin
      lim = LW'(LINE_LIMIT);
    end
  end

  always_comb begin
    phase_d      = phase_q;
    reply_d      = reply_q;
    cnt_d        = cnt_q;
    is_text      = 1'b0;
    push_o.push  = 1'b0;
    push_o.entry = '{op: OP_CHAR, byte_a: rx_byte_i, byte_b: reply_q, len: cnt_ext[LEN_W-1:0]};
    if (accept_i) begin
      if (stream_end_i) begin
        phase_d     = PH_TEXT;
        reply_d     = B_ZERO;
        cnt_d       = '0;
        push_o.push = 1'b1;
        push_o.entry.op = (cnt_q != '0) ? OP_END : OP_EMPTY;
      end else if (!cfg_i.telnet_answer) begin
        phase_d = PH_TEXT;
        is_text = 1'b1;
      end else begin
        unique case (phase_q)
          PH_OPT: begin
            phase_d         = PH_TEXT;
            reply_d         = B_ZERO;
            push_o.push     = 1'b1;
            push_o.entry.op = OP_REPLY;
          end
          PH_CMD: begin
            if (rx_byte_i != B_IAC) begin
              phase_d = PH_OPT;
              if (rx_byte_i == B_WILL || rx_byte_i == B_WONT) begin
                reply_d = B_DONT;
              end else if (rx_byte_i == B_DO || rx_byte_i == B_DONT) begin
                reply_d = B_WONT;
              end else begin
                reply_d = B_ZERO;
              end
            end
          end
          default: begin
            if (rx_byte_i == B_IAC) begin
              phase_d = PH_CMD;
            end else begin
              is_text = 1'b1;
            end
          end
        endcase
      end
      if (is_text) begin
        if (is_term) begin
          if (cnt_q != '0) begin
            push_o.push     = 1'b1;
            push_o.entry.op = OP_END;
            cnt_d           = '0;
          end
        end else begin
          push_o.push      = 1'b1;
          push_o.entry.len = inc_ext[LEN_W-1:0];
          if (inc_ext >= lim) begin
            push_o.entry.op = OP_CHAR_END;
            cnt_d           = '0;
          end else begin
            push_o.entry.op = OP_CHAR;
            cnt_d           = cnt_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TEXT;
      reply_q <= B_ZERO;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      reply_q <= reply_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- sv/trlf_back.sv -----
// Back end: expands each queued action into one to three result
// transactions through a registered output stage. Uses trlf_pkg.
`timescale 1ns / 1ps

module trlf_back
  import trlf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  entry_t            head_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output kind_e             kind_o,
  output logic [7:0]        byte_o,
  output logic [LEN_W-1:0]  len_o,
  output logic              last_o
);

  logic [1:0]        idx_q, idx_d;
  logic              valid_q, valid_d;
  kind_e             kind_q, kind_d;
  logic [7:0]        byte_q, byte_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              last_q, last_d;
  logic              load;

  assign load = head_valid_i && (!valid_q || m_ready_i);

  always_comb begin
    kind_d = K_CHAR;
    byte_d = B_ZERO;
    len_d  = '0;
    last_d = 1'b1;
    unique case (head_i.op)
      OP_CHAR: begin
        byte_d = head_i.byte_a;
      end
      OP_CHAR_END: begin
        if (idx_q == 2'd0) begin
          byte_d = head_i.byte_a;
          last_d = 1'b0;
        end else begin
          kind_d = K_END;
          len_d  = head_i.len;
        end
      end
      OP_END: begin
        kind_d = K_END;
        len_d  = head_i.len;
      end
      OP_EMPTY: begin
        kind_d = K_EMPTY;
      end
      OP_REPLY: begin
        kind_d = K_REPLY;
        case (idx_q)
          2'd0:    byte_d = B_IAC;
          2'd1:    byte_d = head_i.byte_b;
          default: byte_d = head_i.byte_a;
        endcase
        last_d = (idx_q == 2'd2);
      end
      default: begin
        kind_d = K_EMPTY;
      end
    endcase
  end

  assign pop_o = load && last_d;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = last_d ? 2'd0 : idx_q + 2'd1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      len_q  <= len_d;
      last_q <= last_d;
    end
  end

  assign m_valid_o = valid_q;
  assign kind_o    = kind_q;
  assign byte_o    = byte_q;
  assign len_o     = len_q;
  assign last_o    = last_q;

endmodule

// ----- sv/telnet_refusing_line_framer_unit.sv -----
// Top level of the telnet refusing line framer: configuration registers,
// front classifier, action queue and result sequencer. Uses trlf_pkg.
`timescale 1ns / 1ps

// Splits received bytes into line characters and line ends; CR, LF and NUL
// end a line, empty lines are skipped, and a line closes at max_line_len.
// With telnet_answer set, IAC <cmd> <opt> is answered by three reply bytes.
// An input transaction with tuser set marks end of stream. Input is taken
// every cycle while the four-entry action queue has room; each byte yields
// zero to three results, which leave at one per cycle from the output
// register while m_axis_tready is high, so throughput is one byte per cycle
// except during replies and character-plus-line-end pairs (three and two results).
module telnet_refusing_line_framer_unit
  import trlf_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = LINE_LIMIT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [LEN_W-1:0]  cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // rx_byte
  input  logic              s_axis_tuser,   // stream_end
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // out_byte, line_length, zero pad
  output logic [1:0]        m_axis_tuser,   // out_kind
  output logic              m_axis_tlast    // out_last
);

  cfg_t             cfg_q;
  push_t            push;
  entry_t           head;
  logic             full, head_valid, pop, accept;
  kind_e            kind;
  logic [7:0]       obyte;
  logic [LEN_W-1:0] olen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.telnet_answer <= 1'b0;
      cfg_q.max_line_len  <= LEN_W'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TELNET_ANSWER: cfg_q.telnet_answer <= cfg_data_i[0];
        REG_MAX_LINE_LEN:  cfg_q.max_line_len  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  trlf_front #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .rx_byte_i    (s_axis_tdata),
    .stream_end_i (s_axis_tuser),
    .push_o       (push)
  );

  trlf_queue #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push.push),
    .wdata_i (push.entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head)
  );

  trlf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .kind_o       (kind),
    .byte_o       (obyte),
    .len_o        (olen),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {5'b0, olen, obyte};

endmodule
